>>> hdl/sequence_reorder_buffer_defines.svh
// Assertion macros shared by the reorder buffer RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check, disabled while reset is asserted.
`define SRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("srb: check failed");
// Next-cycle implication check, disabled while reset is asserted.
`define SRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("srb: check failed");
`else
`define SRB_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SRB_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> hdl/srb_pkg.sv
// Shared widths, result codes and controller/datapath interface structs
// for the sequence reorder buffer. No dependencies.
package srb_pkg;

    localparam int SESSION_W   = 64;
    localparam int SEQ_W       = 64;
    localparam int TAG_W       = 16;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam int S_TDATA_W = SESSION_W + SEQ_W + TAG_W;
    localparam int M_TDATA_W = TAG_W + SEQ_W;
    localparam int M_TUSER_W = 3;

    typedef enum logic [M_TUSER_W-1:0] {
        ST_INORDER  = 3'd0,
        ST_ERROR    = 3'd1,
        ST_BUFFERED = 3'd2,
        ST_STALE    = 3'd3,
        ST_DUP      = 3'd4,
        ST_OTHER    = 3'd5,
        ST_BEYOND   = 3'd6
    } status_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;     // latch arriving item and its compares
        logic emit_first;  // load result for the arriving item
        logic emit_drain;  // load result for the parked frame at the expected slot
        logic drain_last;  // that drained result closes the item's run
    } srb_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic first_more;  // a parked frame follows the first result
        logic drain_more;  // a parked frame follows the one being drained
    } srb_stat_t;

endpackage

>>> hdl/sequence_reorder_buffer.sv
// Sequence-number reorder buffer for one receiving session. Each accepted item is one
// arriving frame; it produces one result for itself (delivered, error, parked, stale,
// duplicate, other session or beyond window) followed by every consecutive parked frame
// that is now in order, up to 16 results per item, the last one flagged by m_tlast.
// Frames ahead of the expected number by 1 to WINDOW-1 are parked; anything further is
// dropped with the beyond-window code. An item is captured with the session compare and
// sequence subtraction, then classified, and then its released parked frames follow as
// the drain walks the slots one per cycle through the single read port of the tag
// memory; the output register stalls all of it while m_tready is low. Slot valid bits
// clear at reset, so the block is ready right after reset.
// Depends on srb_pkg, srb_ctrl and srb_dp.
module sequence_reorder_buffer import srb_pkg::*; #(
    parameter int WINDOW   = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration: own session identifier
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [SESSION_W-1:0] cfg_data,
    // arriving frames
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // frame_session[63:0], seq_num[127:64], frame_tag[143:128]
    input  logic                 s_tuser,   // is_error
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_tag[15:0], out_seq[79:16]
    output logic [M_TUSER_W-1:0] m_tuser,   // status[2:0]
    output logic                 m_tlast
);

    srb_cmd_t  cmd;
    srb_stat_t stat;

    assign cfg_ready = 1'b1;

    srb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srb_dp #(
        .WINDOW   (WINDOW),
        .TAG_BITS (TAG_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> hdl/srb_ctrl.sv
// Sequencing state machine of the reorder buffer: capture, decide, drain.
// Depends on srb_pkg for the command and status structs.
module srb_ctrl import srb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  srb_stat_t stat,
    output srb_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_DRAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (stat.out_free) begin
                    cmd.emit_first = 1'b1;
                    count_next     = CNT_W'(1);
                    state_next     = stat.first_more ? S_DRAIN : S_IDLE;
                end
            end
            S_DRAIN: begin
                if (stat.out_free) begin
                    cmd.emit_drain = 1'b1;
                    count_next     = count_reg + 1'b1;
                    // stop at the result limit; leftovers drain on the next item
                    cmd.drain_last = (count_next == CNT_W'(MAX_RESULTS)) || !stat.drain_more;
                    if (cmd.drain_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

>>> hdl/srb_dp.sv
// Datapath of the reorder buffer: session register, expected number, slot
// valid bits, parked-tag memory and the output register. Uses srb_pkg.
`include "sequence_reorder_buffer_defines.svh"
module srb_dp import srb_pkg::*; #(
    parameter int WINDOW   = 16,
    parameter int TAG_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic [SESSION_W-1:0] cfg_data,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,
    output logic                 m_tlast,
    input  srb_cmd_t             cmd,
    output srb_stat_t            stat
);

    localparam int SW  = $clog2(WINDOW);
    localparam int SW1 = SW + 1;
    localparam int STW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (s == SW'(WINDOW - 1)) ? '0 : s + 1'b1;
    endfunction

    // input fields
    logic [SESSION_W-1:0] s_sess;
    logic [SEQ_W-1:0]     s_seq;
    logic [TAG_W-1:0]     s_tag;

    assign s_sess = s_tdata[SESSION_W-1:0];
    assign s_seq  = s_tdata[SESSION_W+SEQ_W-1:SESSION_W];
    assign s_tag  = s_tdata[S_TDATA_W-1:SESSION_W+SEQ_W];

    // control state
    logic [SESSION_W-1:0] own_session_reg;
    logic [SEQ_W-1:0]     expected_reg, expected_next;
    logic [SW-1:0]        exp_slot_reg, exp_slot_next;
    logic [WINDOW-1:0]    slot_valid_reg, slot_valid_next;
    logic                 m_valid_reg, m_valid_next;

    // captured item
    logic [SEQ_W-1:0] in_seq_reg;
    logic [STW-1:0]   in_tag_reg;
    logic             in_err_reg;
    logic             in_sess_eq_reg;
    logic             in_stale_reg;
    logic [SEQ_W-1:0] dist_reg;

    // parked tags
    logic [STW-1:0] tag_mem [WINDOW];
    logic [STW-1:0] mem_rd_reg;

    // output register payload
    status_t          m_status_reg;
    logic [TAG_W-1:0] m_tag_reg;
    logic [SEQ_W-1:0] m_seq_reg;
    logic             m_last_reg;

    logic [SEQ_W:0]  diff;
    logic            beyond;
    logic [SW1-1:0]  arr_sum;
    logic [SW-1:0]   arr_slot;
    logic            dup;
    status_t         first_status;
    logic            is_inorder;
    logic            park_we;
    logic            advance;
    logic [SW-1:0]   exp_slot_inc;

    assign diff = {1'b0, s_seq} - {1'b0, expected_reg};

    assign beyond   = (dist_reg >= SEQ_W'(WINDOW));
    assign arr_sum  = {1'b0, exp_slot_reg} + {1'b0, dist_reg[SW-1:0]};
    assign arr_slot = (arr_sum >= SW1'(WINDOW)) ? SW'(arr_sum - SW1'(WINDOW))
                                                : arr_sum[SW-1:0];
    assign dup      = slot_valid_reg[arr_slot];

    always_comb begin
        if (!in_sess_eq_reg) begin
            first_status = ST_OTHER;
        end else if (in_err_reg) begin
            first_status = ST_ERROR;
        end else if (in_stale_reg) begin
            first_status = ST_STALE;
        end else if (beyond) begin
            first_status = ST_BEYOND;
        end else if (dup) begin
            first_status = ST_DUP;
        end else if (dist_reg == '0) begin
            first_status = ST_INORDER;
        end else begin
            first_status = ST_BUFFERED;
        end
    end

    assign is_inorder   = (first_status == ST_INORDER);
    assign park_we      = cmd.emit_first && (first_status == ST_BUFFERED);
    assign exp_slot_inc = slot_inc(exp_slot_reg);
    assign advance      = (cmd.emit_first && is_inorder) || cmd.emit_drain;

    assign stat.out_free   = !m_valid_reg || m_tready;
    assign stat.first_more = is_inorder ? slot_valid_reg[exp_slot_inc]
                                        : slot_valid_reg[exp_slot_reg];
    assign stat.drain_more = slot_valid_reg[exp_slot_inc];

    always_comb begin
        expected_next   = advance ? expected_reg + 1'b1 : expected_reg;
        exp_slot_next   = advance ? exp_slot_inc : exp_slot_reg;
        slot_valid_next = slot_valid_reg;
        if (park_we) begin
            slot_valid_next[arr_slot] = 1'b1;
        end
        if (cmd.emit_drain) begin
            slot_valid_next[exp_slot_reg] = 1'b0;
        end
        m_valid_next = (cmd.emit_first || cmd.emit_drain) ? 1'b1
                     : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_session_reg <= '0;
            expected_reg    <= '0;
            exp_slot_reg    <= '0;
            slot_valid_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_valid) begin
                own_session_reg <= cfg_data;
            end
            expected_reg   <= expected_next;
            exp_slot_reg   <= exp_slot_next;
            slot_valid_reg <= slot_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_seq_reg     <= s_seq;
            in_tag_reg     <= s_tag[STW-1:0];
            in_err_reg     <= s_tuser;
            in_sess_eq_reg <= (s_sess == own_session_reg);
            in_stale_reg   <= diff[SEQ_W];
            dist_reg       <= diff[SEQ_W-1:0];
        end
    end

    // Parked slot never equals the slot being read, so read and write never collide.
    always_ff @(posedge aclk) begin
        if (park_we) begin
            tag_mem[arr_slot] <= in_tag_reg;
        end
        mem_rd_reg <= tag_mem[exp_slot_next];
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_first) begin
            m_status_reg <= first_status;
            m_tag_reg    <= TAG_W'(in_tag_reg);
            m_seq_reg    <= in_seq_reg;
            m_last_reg   <= !stat.first_more;
        end else if (cmd.emit_drain) begin
            m_status_reg <= ST_INORDER;
            m_tag_reg    <= TAG_W'(mem_rd_reg);
            m_seq_reg    <= expected_reg;
            m_last_reg   <= cmd.drain_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_seq_reg, m_tag_reg};
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;

    `SRB_ASSERT_IMP(a_drain_from_valid, aclk, aresetn, cmd.emit_drain, slot_valid_reg[exp_slot_reg])
    `SRB_ASSERT_IMP(a_park_not_expected, aclk, aresetn, park_we, arr_slot != exp_slot_reg)
    `SRB_ASSERT_NXT(a_park_sets_valid, aclk, aresetn, park_we, slot_valid_reg[$past(arr_slot)])
    `SRB_ASSERT_NXT(a_drain_advances, aclk, aresetn, cmd.emit_drain, expected_reg == $past(expected_reg) + 1'b1)

endmodule
